### sv/arpc_pkg.sv
package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int TTL_W = 8;
  localparam int OP_W  = 3;
  localparam int ST_W  = 3;
  localparam int IDX_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
  localparam logic [OP_W-1:0] OP_REQUEST = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLY   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 3'd0;
  localparam logic [ST_W-1:0] ST_HIT   = 3'd1;
  localparam logic [ST_W-1:0] ST_MISS  = 3'd2;
  localparam logic [ST_W-1:0] ST_REPLY = 3'd3;
  localparam logic [ST_W-1:0] ST_READ  = 3'd4;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_IP       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TTL = 2'd2;

  localparam logic [TTL_W-1:0] DEFAULT_TTL_RST = 8'hff;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [TTL_W-1:0] ttl;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIX,
    S_DONE
  } state_t;

endpackage

### sv/arpc_table.sv
module arpc_table #(
  parameter int ENTRIES = 8,
  parameter int ADDR_W  = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output arpc_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  arpc_pkg::entry_t     wr_data
);
  import arpc_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  entry_t             rd_q_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### sv/arpc_ctrl.sv
module arpc_ctrl #(
  parameter int ENTRIES = 8,
  parameter int ADDR_W  = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [arpc_pkg::OP_W-1:0]     in_operation,
  input  logic [arpc_pkg::IP_W-1:0]     in_target_ip,
  input  logic [arpc_pkg::IP_W-1:0]     in_sender_ip,
  input  logic [arpc_pkg::MAC_W-1:0]    in_sender_mac,
  input  logic [arpc_pkg::IDX_W-1:0]    in_entry_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [arpc_pkg::ST_W-1:0]     out_status,
  output logic [arpc_pkg::IP_W-1:0]     out_ip,
  output logic [arpc_pkg::MAC_W-1:0]    out_mac,
  output logic [arpc_pkg::TTL_W-1:0]    out_ttl,
  input  logic [arpc_pkg::IP_W-1:0]     my_ip,
  input  logic [arpc_pkg::TTL_W-1:0]    default_ttl,
  output logic                          rd_en,
  output logic [ADDR_W-1:0]             rd_addr,
  input  arpc_pkg::entry_t              rd_data,
  output logic                          wr_en,
  output logic [ADDR_W-1:0]             wr_addr,
  output arpc_pkg::entry_t              wr_data
);
  import arpc_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]    ENTRIES_CNT = (IDX_W + 1)'(ENTRIES);

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [IP_W-1:0]     tip_r, tip_nxt;
  logic [IP_W-1:0]     sip_r, sip_nxt;
  logic [MAC_W-1:0]    smac_r, smac_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic                hit_r, hit_nxt;
  logic                free_found_r, free_found_nxt;
  logic [ADDR_W-1:0]   free_addr_r, free_addr_nxt;
  logic [MAC_W-1:0]    free_mac_r, free_mac_nxt;
  logic [ST_W-1:0]     res_status_r, res_status_nxt;
  logic [IP_W-1:0]     res_ip_r, res_ip_nxt;
  logic [MAC_W-1:0]    res_mac_r, res_mac_nxt;
  logic [TTL_W-1:0]    res_ttl_r, res_ttl_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]     out_status_r;
  logic [IP_W-1:0]     out_ip_r;
  logic [MAC_W-1:0]    out_mac_r;
  logic [TTL_W-1:0]    out_ttl_r;

  logic                in_fire;
  logic                in_range;
  logic                out_load;
  logic                fix_wr;

  assign in_fire  = in_valid && in_ready;
  assign in_range = {1'b0, in_entry_index} < ENTRIES_CNT;
  assign fix_wr   = (state_r == S_FIX) && !hit_r && free_found_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_operation)
            OP_TICK, OP_LOOKUP, OP_REPLY: state_nxt = S_SCAN;
            OP_READ:                      state_nxt = in_range ? S_DRAIN : S_DONE;
            default:                      state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_ADDR) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = (op_r == OP_LOOKUP) ? S_FIX : S_DONE;
      S_FIX:   state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = cnt_r;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_fire && (in_operation == OP_READ) && in_range;
        rd_addr  = in_entry_index[ADDR_W-1:0];
      end
      S_SCAN: rd_en = 1'b1;
      S_DONE: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    op_nxt         = op_r;
    tip_nxt        = tip_r;
    sip_nxt        = sip_r;
    smac_nxt       = smac_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = rd_en;
    pend_addr_nxt  = rd_addr;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    free_addr_nxt  = free_addr_r;
    free_mac_nxt   = free_mac_r;
    res_status_nxt = res_status_r;
    res_ip_nxt     = res_ip_r;
    res_mac_nxt    = res_mac_r;
    res_ttl_nxt    = res_ttl_r;
    wr_en          = 1'b0;
    wr_addr        = pend_addr_r;
    wr_data        = rd_data;

    if (in_fire) begin
      op_nxt         = in_operation;
      tip_nxt        = in_target_ip;
      sip_nxt        = in_sender_ip;
      smac_nxt       = in_sender_mac;
      cnt_nxt        = '0;
      hit_nxt        = 1'b0;
      free_found_nxt = 1'b0;
      res_status_nxt = ST_DONE;
      res_ip_nxt     = '0;
      res_mac_nxt    = '0;
      res_ttl_nxt    = '0;
      case (in_operation)
        OP_LOOKUP: begin
          res_status_nxt = ST_MISS;
          res_ip_nxt     = in_target_ip;
        end
        OP_REQUEST: begin
          if (in_target_ip == my_ip) begin
            res_status_nxt = ST_REPLY;
            res_ip_nxt     = in_sender_ip;
            res_mac_nxt    = in_sender_mac;
          end
        end
        OP_READ: begin
          if (!in_range) begin
            res_status_nxt = ST_RANGE;
          end
        end
        default: ;
      endcase
    end

    if (state_r == S_SCAN) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    if (pend_r) begin
      case (op_r)
        OP_TICK: begin
          if (rd_data.ttl != '0) begin
            wr_en       = 1'b1;
            wr_data.ttl = rd_data.ttl - 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (!hit_r && rd_data.ttl != '0 && rd_data.ip == tip_r) begin
            hit_nxt        = 1'b1;
            res_status_nxt = ST_HIT;
            res_mac_nxt    = rd_data.mac;
          end
          if (!free_found_r && rd_data.ttl == '0) begin
            free_found_nxt = 1'b1;
            free_addr_nxt  = pend_addr_r;
            free_mac_nxt   = rd_data.mac;
          end
        end
        OP_REPLY: begin
          if (rd_data.ip == sip_r) begin
            wr_en       = 1'b1;
            wr_data.mac = smac_r;
            wr_data.ttl = default_ttl;
          end
        end
        OP_READ: begin
          res_status_nxt = ST_READ;
          res_ip_nxt     = rd_data.ip;
          res_mac_nxt    = rd_data.mac;
          res_ttl_nxt    = rd_data.ttl;
        end
        default: ;
      endcase
    end

    // miss claims the first free slot
    if (fix_wr) begin
      wr_en   = 1'b1;
      wr_addr = free_addr_r;
      wr_data = '{ip: tip_r, mac: free_mac_r, ttl: '0};
    end

    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    tip_r        <= tip_nxt;
    sip_r        <= sip_nxt;
    smac_r       <= smac_nxt;
    cnt_r        <= cnt_nxt;
    pend_addr_r  <= pend_addr_nxt;
    hit_r        <= hit_nxt;
    free_found_r <= free_found_nxt;
    free_addr_r  <= free_addr_nxt;
    free_mac_r   <= free_mac_nxt;
    res_status_r <= res_status_nxt;
    res_ip_r     <= res_ip_nxt;
    res_mac_r    <= res_mac_nxt;
    res_ttl_r    <= res_ttl_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_ip_r     <= res_ip_r;
      out_mac_r    <= res_mac_r;
      out_ttl_r    <= res_ttl_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_ip     = out_ip_r;
  assign out_mac    = out_mac_r;
  assign out_ttl    = out_ttl_r;

`ifndef SYNTHESIS
  a_no_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r != S_IDLE)
    else $error("table write while idle");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> wr_addr != rd_addr)
    else $error("read and write of the same entry in one cycle");

  a_pend_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(rd_en))
    else $error("entry processed without a read");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_IDLE) |=> out_valid_r)
    else $error("result lost on leaving done");

  a_fix_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIX |-> (op_r == OP_LOOKUP && $past(state_r) == S_DRAIN))
    else $error("slot claim outside lookup");
`endif

endmodule

### sv/arp_cache_with_aging_core.sv
// tick and reply scan all entries; lookup scans them, then claims a free slot on a miss;
// in-range read reads one entry; other reads, requests and unknown operations skip the table
// one transaction at a time; the entry scan reads the table memory once per cycle
// a new transaction is taken once the previous result is loaded into the output register
// synchronous active-low reset; entries read as zero through per-entry valid flags,
// no clearing pass; my_ip and my_mac reset to zero, default_ttl to 255
module arp_cache_with_aging_core #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [arpc_pkg::OP_W-1:0]         in_operation,
  input  logic [arpc_pkg::IP_W-1:0]         in_target_ip,
  input  logic [arpc_pkg::IP_W-1:0]         in_sender_ip,
  input  logic [arpc_pkg::MAC_W-1:0]        in_sender_mac,
  input  logic [arpc_pkg::IDX_W-1:0]        in_entry_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [arpc_pkg::ST_W-1:0]         out_status,
  output logic [arpc_pkg::IP_W-1:0]         out_ip,
  output logic [arpc_pkg::MAC_W-1:0]        out_mac,
  output logic [arpc_pkg::TTL_W-1:0]        out_ttl,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import arpc_pkg::*;

  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [IP_W-1:0]   my_ip_r;
  logic [MAC_W-1:0]  my_mac_r;
  logic [TTL_W-1:0]  default_ttl_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_ip_r       <= '0;
      my_mac_r      <= '0;
      default_ttl_r <= DEFAULT_TTL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MY_IP:       my_ip_r       <= cfg_data[IP_W-1:0];
        CFG_MY_MAC:      my_mac_r      <= cfg_data[MAC_W-1:0];
        CFG_DEFAULT_TTL: default_ttl_r <= cfg_data[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  arpc_table #(
    .ENTRIES (TABLE_ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  arpc_ctrl #(
    .ENTRIES (TABLE_ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_target_ip   (in_target_ip),
    .in_sender_ip   (in_sender_ip),
    .in_sender_mac  (in_sender_mac),
    .in_entry_index (in_entry_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_ip         (out_ip),
    .out_mac        (out_mac),
    .out_ttl        (out_ttl),
    .my_ip          (my_ip_r),
    .default_ttl    (default_ttl_r),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

endmodule
